### src/quaternion_to_euler_angles_defines.svh
// Assertion helpers for the quaternion to Euler angle converter
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define QTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qte: same-cycle check failed");

// Next-cycle implication
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qte: next-cycle check failed");

`endif

### src/qte_pkg.sv
package qte_pkg;

  // Product sums: Q28, worst case magnitude 2^32
  localparam int unsigned TermW    = 34;
  // CORDIC x/y datapath, room for the CORDIC gain
  localparam int unsigned CordW    = 38;
  // Angles in degrees, Q24
  localparam int unsigned AngW     = 34;
  // Square root: radicand up to 2^56, root up to 2^28
  localparam int unsigned RadW     = 57;
  localparam int unsigned SqW      = 56;
  localparam int unsigned RootW    = 29;
  localparam int unsigned MagW     = 28;
  localparam int unsigned SqrtSteps = 29;
  localparam int unsigned AtanLen  = 24;
  localparam int unsigned AtanIdxW = 5;
  localparam int unsigned AngFracQ = 24;

  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [AngW-1:0]  angle_t;

  localparam term_t  OneQ28 = 34'sh0_1000_0000;
  localparam angle_t Deg180 = 34'sd3019898880;
  localparam angle_t Deg90  = 34'sd1509949440;

  // atan(2^-i) in degrees, Q24, rounded to nearest
  localparam angle_t AtanTab [AtanLen] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
    34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
    34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
    34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
    34'sd917,       34'sd458,       34'sd229,       34'sd115
  };

  // Trig terms of one quaternion
  typedef struct packed {
    term_t sr;
    term_t cr;
    term_t sp;
    term_t sy;
    term_t cy;
    logic  clamped;
  } terms_t;

  // One vectoring CORDIC lane; hold freezes a lane whose angle is already known
  typedef struct packed {
    cord_t  y;
    cord_t  x;
    angle_t z;
    logic   hold;
  } lane_t;

  // Pitch side info carried next to the CORDIC lanes
  typedef struct packed {
    logic clamped;
    logic sp_neg;
  } pitch_side_t;

endpackage

### src/qte_terms.sv
module qte_terms (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [15:0]        quat_w_i,
  input  logic signed [15:0]        quat_x_i,
  input  logic signed [15:0]        quat_y_i,
  input  logic signed [15:0]        quat_z_i,
  output logic                      valid_o,
  output qte_pkg::terms_t           terms_o,
  output logic [qte_pkg::SqW-1:0]   sq_o
);
  import qte_pkg::*;

  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] yz;
    logic signed [31:0] wy;
    logic signed [31:0] zx;
    logic signed [31:0] wz;
    logic signed [31:0] xy;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
  } prod_t;

  prod_t              prod_d, prod_q;
  terms_t             terms_d, terms_q, terms2_q;
  logic [SqW-1:0]     sq_d, sq_q;
  term_t              sp_abs;
  logic [MagW-1:0]    sp_mag;
  logic               v1_q, v2_q, v3_q;

  // Stage 1: the nine component products
  always_comb begin
    prod_d.wx = 32'(quat_w_i) * 32'(quat_x_i);
    prod_d.yz = 32'(quat_y_i) * 32'(quat_z_i);
    prod_d.wy = 32'(quat_w_i) * 32'(quat_y_i);
    prod_d.zx = 32'(quat_z_i) * 32'(quat_x_i);
    prod_d.wz = 32'(quat_w_i) * 32'(quat_z_i);
    prod_d.xy = 32'(quat_x_i) * 32'(quat_y_i);
    prod_d.xx = 32'(quat_x_i) * 32'(quat_x_i);
    prod_d.yy = 32'(quat_y_i) * 32'(quat_y_i);
    prod_d.zz = 32'(quat_z_i) * 32'(quat_z_i);
  end

  // Stage 2: product sums in Q28, pitch range check
  always_comb begin
    terms_d.sr = (term_t'(prod_q.wx) + term_t'(prod_q.yz)) <<< 1;
    terms_d.cr = OneQ28 - ((term_t'(prod_q.xx) + term_t'(prod_q.yy)) <<< 1);
    terms_d.sp = (term_t'(prod_q.wy) - term_t'(prod_q.zx)) <<< 1;
    terms_d.sy = (term_t'(prod_q.wz) + term_t'(prod_q.xy)) <<< 1;
    terms_d.cy = OneQ28 - ((term_t'(prod_q.yy) + term_t'(prod_q.zz)) <<< 1);
    terms_d.clamped = (terms_d.sp >= OneQ28) || (terms_d.sp <= -OneQ28);
  end

  // Stage 3: square of the pitch term, zero when clamped
  always_comb begin
    sp_abs = terms_q.sp[TermW-1] ? -terms_q.sp : terms_q.sp;
    sp_mag = terms_q.clamped ? '0 : sp_abs[MagW-1:0];
    sq_d   = sp_mag * sp_mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      terms_q  <= terms_d;
      terms2_q <= terms_q;
      sq_q     <= sq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign terms_o = terms2_q;
  assign sq_o    = sq_q;

endmodule

### src/qte_isqrt.sv
module qte_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  qte_pkg::terms_t           terms_i,
  input  logic [qte_pkg::SqW-1:0]   sq_i,
  output logic                      valid_o,
  output qte_pkg::terms_t           terms_o,
  output logic [qte_pkg::RootW-1:0] root_o
);
  import qte_pkg::*;

  localparam logic [RadW-1:0] RadOne = {1'b1, {(RadW-1){1'b0}}};

  logic [RadW-1:0] rem_q   [SqrtSteps+1];
  logic [RadW:0]   res_q   [SqrtSteps+1];
  terms_t          terms_q [SqrtSteps+1];
  logic            v_q     [SqrtSteps+1];
  logic [RadW-1:0] rem_d   [SqrtSteps];
  logic [RadW:0]   res_d   [SqrtSteps];
  logic [RadW:0]   trial   [SqrtSteps];
  logic [RadW:0]   bitv    [SqrtSteps];

  // One root bit per stage: restoring square root, bit walks down two places
  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      bitv[k]  = (RadW+1)'(1) << (2 * (SqrtSteps - 1 - k));
      trial[k] = res_q[k] + bitv[k];
      if ({1'b0, rem_q[k]} >= trial[k]) begin
        rem_d[k] = rem_q[k] - trial[k][RadW-1:0];
        res_d[k] = (res_q[k] >> 1) + bitv[k];
      end else begin
        rem_d[k] = rem_q[k];
        res_d[k] = res_q[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]   <= RadOne - {1'b0, sq_i};
      res_q[0]   <= '0;
      terms_q[0] <= terms_i;
      for (int k = 0; k < SqrtSteps; k++) begin
        rem_q[k+1]   <= rem_d[k];
        res_q[k+1]   <= res_d[k];
        terms_q[k+1] <= terms_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= SqrtSteps; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 0; k < SqrtSteps; k++) begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  assign valid_o = v_q[SqrtSteps];
  assign terms_o = terms_q[SqrtSteps];
  assign root_o  = res_q[SqrtSteps][RootW-1:0];

endmodule

### src/qte_cordic.sv
module qte_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  qte_pkg::terms_t           terms_i,
  input  logic [qte_pkg::RootW-1:0] root_i,
  output logic                      valid_o,
  output qte_pkg::angle_t           roll_o,
  output qte_pkg::angle_t           pitch_o,
  output qte_pkg::angle_t           yaw_o,
  output qte_pkg::pitch_side_t      side_o
);
  import qte_pkg::*;

  localparam int unsigned Lanes = 3;

  lane_t       lane_q [STAGES+1][Lanes];
  lane_t       lane_d [STAGES][Lanes];
  lane_t       init_d [Lanes];
  pitch_side_t side_q [STAGES+1];
  logic        v_q    [STAGES+1];
  term_t       root_t;

  // Quadrant fold and the axis cases whose angle is known up front
  function automatic lane_t lane_init(input term_t y, input term_t x);
    lane_t l;
    l.y    = cord_t'(y);
    l.x    = cord_t'(x);
    l.z    = '0;
    l.hold = 1'b0;
    if (y == '0) begin
      l.hold = 1'b1;
      l.z    = (x < 0) ? Deg180 : '0;
    end else if (x == '0) begin
      l.hold = 1'b1;
      l.z    = (y > 0) ? Deg90 : -Deg90;
    end else if (x < 0) begin
      l.z = (y > 0) ? Deg180 : -Deg180;
      l.x = -cord_t'(x);
      l.y = -cord_t'(y);
    end
    return l;
  endfunction

  // One micro-rotation, floor shifts
  function automatic lane_t lane_step(input lane_t l, input int unsigned i);
    lane_t r;
    cord_t dx;
    cord_t dy;
    r  = l;
    dx = l.y >>> i;
    dy = l.x >>> i;
    if (!l.hold) begin
      if (!l.y[CordW-1]) begin
        r.x = l.x + dx;
        r.y = l.y - dy;
        r.z = l.z + AtanTab[AtanIdxW'(i)];
      end else begin
        r.x = l.x - dx;
        r.y = l.y + dy;
        r.z = l.z - AtanTab[AtanIdxW'(i)];
      end
    end
    return r;
  endfunction

  assign root_t = term_t'(root_i);

  always_comb begin
    init_d[0] = lane_init(terms_i.sr, terms_i.cr);
    init_d[1] = lane_init(terms_i.sp, root_t);
    init_d[2] = lane_init(terms_i.sy, terms_i.cy);
    for (int s = 0; s < STAGES; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        lane_d[s][l] = lane_step(lane_q[s][l], s);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0].clamped <= terms_i.clamped;
      side_q[0].sp_neg  <= terms_i.sp[TermW-1];
      for (int l = 0; l < Lanes; l++) begin
        lane_q[0][l] <= init_d[l];
      end
      for (int s = 0; s < STAGES; s++) begin
        side_q[s+1] <= side_q[s];
        for (int l = 0; l < Lanes; l++) begin
          lane_q[s+1][l] <= lane_d[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= STAGES; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 0; s < STAGES; s++) begin
        v_q[s+1] <= v_q[s];
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign roll_o  = lane_q[STAGES][0].z;
  assign pitch_o = lane_q[STAGES][1].z;
  assign yaw_o   = lane_q[STAGES][2].z;
  assign side_o  = side_q[STAGES];

endmodule

### src/quaternion_to_euler_angles.sv
// Quaternion to Euler angles, Z-Y-X (yaw-pitch-roll) order.
// Input channel: in_valid_i/in_ready_o with quat_w_i..quat_z_i, signed Q2.14.
// Output channel: out_valid_o/out_ready_i with roll, pitch and yaw in degrees
// scaled by 2^ANGLE_FRAC_BITS, and pitch_clamped_o when |pitch term| >= 1.
// One word per channel per handshake; one result word per input word, in order.
// Pipeline order: products and sums, the pipelined square root for the pitch
// cosine, the vectoring CORDIC, then rounding into the output register.
// Throughput is one word per clock while the output is not stalled; every
// stage is a register stage.
// When the receiver stalls, the result stays in the output register and the
// pipeline keeps moving as long as its last stage is empty, so words keep
// entering until the pipe backs up to the input.
// Reset clears only the valid bits; the data registers are not reset.
module quaternion_to_euler_angles #(
  parameter int unsigned ANGLE_FRAC_BITS = 7,
  parameter int unsigned CORDIC_STAGES   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_deg_o,
  output logic signed [14:0] pitch_deg_o,
  output logic signed [15:0] yaw_deg_o,
  output logic               pitch_clamped_o
);
  import qte_pkg::*;

  `include "quaternion_to_euler_angles_defines.svh"

  localparam int unsigned     Shift    = AngFracQ - ANGLE_FRAC_BITS;
  localparam logic [AngW-1:0] Half     = AngW'(1) << (Shift - 1);
  localparam logic [AngW-1:0] Lim180   = AngW'(180) << ANGLE_FRAC_BITS;
  localparam logic [AngW-1:0] Lim90    = AngW'(90) << ANGLE_FRAC_BITS;
  localparam logic [14:0]     PitchPos = Lim90[14:0];
  localparam logic [14:0]     PitchNeg = 15'(-Lim90);

  logic           en;
  logic           out_free;
  logic           terms_valid, sqrt_valid, cord_valid;
  terms_t         terms, terms_s;
  logic [SqW-1:0] sq;
  logic [RootW-1:0] root;
  angle_t         roll_z, pitch_z, yaw_z;
  pitch_side_t    side;
  angle_t         roll_r, pitch_r, yaw_r;

  logic               out_valid_q, out_valid_d;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic               clamped_q;

  // Pipeline advances when the output register can take a word or the last
  // stage holds only a bubble
  assign out_free   = !out_valid_q || out_ready_i;
  assign en         = out_free || !cord_valid;
  assign in_ready_o = en;

  qte_terms u_terms (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .valid_o  (terms_valid),
    .terms_o  (terms),
    .sq_o     (sq)
  );

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (terms_valid),
    .terms_i (terms),
    .sq_i    (sq),
    .valid_o (sqrt_valid),
    .terms_o (terms_s),
    .root_o  (root)
  );

  qte_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .terms_i (terms_s),
    .root_i  (root),
    .valid_o (cord_valid),
    .roll_o  (roll_z),
    .pitch_o (pitch_z),
    .yaw_o   (yaw_z),
    .side_o  (side)
  );

  // Round Q24 degrees to nearest, ties away from zero, then saturate
  function automatic angle_t round_sat(input angle_t z, input logic [AngW-1:0] lim);
    logic [AngW-1:0] mag;
    logic [AngW-1:0] r;
    mag = z[AngW-1] ? AngW'(-z) : AngW'(z);
    r   = (mag + Half) >> Shift;
    if (r > lim) begin
      r = lim;
    end
    return z[AngW-1] ? -angle_t'(r) : angle_t'(r);
  endfunction

  always_comb begin
    roll_r = round_sat(roll_z, Lim180);
    yaw_r  = round_sat(yaw_z, Lim180);
    if (side.clamped) begin
      pitch_r = side.sp_neg ? -angle_t'(Lim90) : angle_t'(Lim90);
    end else begin
      pitch_r = round_sat(pitch_z, Lim90);
    end
  end

  // Output register
  assign out_valid_d = out_free ? cord_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      roll_q    <= roll_r[15:0];
      pitch_q   <= pitch_r[14:0];
      yaw_q     <= yaw_r[15:0];
      clamped_q <= side.clamped;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign roll_deg_o      = roll_q;
  assign pitch_deg_o     = pitch_q;
  assign yaw_deg_o       = yaw_q;
  assign pitch_clamped_o = clamped_q;

  // A clamped pitch is always exactly plus or minus 90 degrees
  `QTE_ASSERT_NOW(a_clamp_value, out_valid_o && pitch_clamped_o, pitch_deg_o == PitchPos || pitch_deg_o == PitchNeg)
  // Input is held off only while a full last stage waits behind a stalled output
  `QTE_ASSERT_NOW(a_ready_stall, !in_ready_o, out_valid_o && !out_ready_i && cord_valid)
  // A word taken while the output is free shows up as valid next cycle
  `QTE_ASSERT_NEXT(a_out_load, out_free && cord_valid, out_valid_o)

endmodule

### dv/tb.sv
module tb;

  // One predicted output word
  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  localparam int          FracBits   = 7;
  localparam int          Stages     = 16;
  localparam int          DrainWait  = 80;
  localparam int          LongHold   = 300;
  localparam longint      CycleLimit = 1000000;
  localparam longint      OneQ28     = 64'sd1 << 28;
  localparam longint      Deg180Q24  = 64'sd3019898880;
  localparam longint      Deg90Q24   = 64'sd1509949440;

  // atan(2^-i) in degrees, Q24
  localparam longint AtanDeg [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  // Scoreboard: predicts angles for each accepted quaternion, checks results
  class angle_board;
    euler_t angles_due[$];
    int     fails;

    function new();
      fails = 0;
    endfunction

    static function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Vectoring CORDIC, angle in degrees Q24
    static function longint cordic_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (y == 0) return (x < 0) ? Deg180Q24 : 0;
      if (x == 0) return (y > 0) ? Deg90Q24 : -Deg90Q24;
      if (x < 0) begin
        z = (y > 0) ? Deg180Q24 : -Deg180Q24;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < Stages && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + AtanDeg[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - AtanDeg[i];
        end
      end
      return z;
    endfunction

    // Round half away from zero to output fraction bits, then saturate
    static function longint round_deg(longint z, longint lim);
      longint mag;
      int     s;
      s   = 24 - FracBits;
      mag = (z < 0) ? -z : z;
      mag = (mag + (64'sd1 << (s - 1))) >>> s;
      if (mag > lim) mag = lim;
      return (z < 0) ? -mag : mag;
    endfunction

    function void note(logic signed [15:0] qw, logic signed [15:0] qx,
                       logic signed [15:0] qy, logic signed [15:0] qz);
      longint w, x, y, z, sr, cr, sp, sy, cy, lim180, lim90, r, p, yw;
      longint unsigned c;
      euler_t e;
      w = qw; x = qx; y = qy; z = qz;
      lim180 = 64'sd180 << FracBits;
      lim90  = 64'sd90 << FracBits;
      sr = 2 * (w * x + y * z);
      cr = OneQ28 - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = OneQ28 - 2 * (y * y + z * z);
      r  = round_deg(cordic_angle(sr, cr), lim180);
      yw = round_deg(cordic_angle(sy, cy), lim180);
      e.clamped = 1'b0;
      if (sp >= OneQ28 || sp <= -OneQ28) begin
        p = (sp > 0) ? lim90 : -lim90;
        e.clamped = 1'b1;
      end else begin
        c = root_floor((64'd1 << 56) - longint'(sp * sp));
        p = round_deg(cordic_angle(sp, longint'(c)), lim90);
      end
      e.roll  = r[15:0];
      e.pitch = p[14:0];
      e.yaw   = yw[15:0];
      angles_due.insert(angles_due.size(), e);
    endfunction

    function void check(euler_t got);
      euler_t e;
      if (angles_due.size() == 0) begin
        $error("unexpected output word: roll %0d pitch %0d yaw %0d",
               got.roll, got.pitch, got.yaw);
        fails++;
        return;
      end
      e = angles_due.pop_front();
      if (got.roll !== e.roll) begin
        $error("roll_deg: expected %0d, got %0d", e.roll, got.roll);
        fails++;
      end
      if (got.pitch !== e.pitch) begin
        $error("pitch_deg: expected %0d, got %0d", e.pitch, got.pitch);
        fails++;
      end
      if (got.yaw !== e.yaw) begin
        $error("yaw_deg: expected %0d, got %0d", e.yaw, got.yaw);
        fails++;
      end
      if (got.clamped !== e.clamped) begin
        $error("pitch_clamped: expected %0b, got %0b", e.clamped, got.clamped);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] roll_deg_o;
  logic signed [14:0] pitch_deg_o;
  logic signed [15:0] yaw_deg_o;
  logic               pitch_clamped_o;

  angle_board board = new();
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;
  longint     cycles = 0;

  quaternion_to_euler_angles dut (.*);

  always #10 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Monitors for both channels
  always @(posedge clk_i) begin
    euler_t got;
    if (rst_ni && in_valid_i && in_ready_o)
      board.note(quat_w_i, quat_x_i, quat_y_i, quat_z_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.roll    = roll_deg_o;
      got.pitch   = pitch_deg_o;
      got.yaw     = yaw_deg_o;
      got.clamped = pitch_clamped_o;
      board.check(got);
    end
  end

  // Receiver: random back-pressure, plus one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Offer one quaternion word and hold it until accepted
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_w_i   <= w;
    quat_x_i   <= x;
    quat_y_i   <= y;
    quat_z_i   <= z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mostly components within plus or minus one, some full-range noise
  task automatic send_random();
    if ($urandom_range(0, 3) == 0)
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_quat(16'($urandom_range(0, 32768) - 16384),
                16'($urandom_range(0, 32768) - 16384),
                16'($urandom_range(0, 32768) - 16384),
                16'($urandom_range(0, 32768) - 16384));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.angles_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, identity, both-zero, zero numerator with
    // negative denominator, zero denominator, gimbal lock both signs
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 8192, 8192, 0);
    send_quat(0, 0, 8192, 8192);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11585, 11585, 11585, -11585);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(0, 0, 32767, 0);
    send_quat(1, 0, 0, 0);
    send_quat(0, 0, 0, -1);
    send_quat(14189, 8192, 0, 0);
    send_quat(8192, -8192, 8192, -8192);
    wait_drained();

    repeat (500) send_random();

    // Long receiver hold while words keep flowing in
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (200) send_random();
    idle_on = 1'b1;
    repeat (400) send_random();
    wait_drained();

    repeat (250) send_random();

    // Final stretch with no idling
    idle_on = 1'b0;
    repeat (200) send_random();
    in_valid_i <= 1'b0;

    while (board.angles_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (board.fails == 0 && board.angles_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
